### design/jsv_pkg.sv
`default_nettype none
package jsv_pkg;

   // parse phases, one-hot
   typedef enum logic [11:0] {
      PH_LEAD     = 12'b0000_0000_0001,
      PH_LIT      = 12'b0000_0000_0010,
      PH_SIGN     = 12'b0000_0000_0100,
      PH_INT      = 12'b0000_0000_1000,
      PH_ZERO     = 12'b0000_0001_0000,
      PH_DOT      = 12'b0000_0010_0000,
      PH_FRAC     = 12'b0000_0100_0000,
      PH_EXP      = 12'b0000_1000_0000,
      PH_EXPSIGN  = 12'b0001_0000_0000,
      PH_EXPDIG   = 12'b0010_0000_0000,
      PH_TRAIL    = 12'b0100_0000_0000,
      PH_ERROR    = 12'b1000_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EXPECT  = 2'd1,
      ST_INVALID = 2'd2,
      ST_NOTSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TY_NULL   = 2'd0,
      TY_FALSE  = 2'd1,
      TY_TRUE   = 2'd2,
      TY_NUMBER = 2'd3
   } value_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6e;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   // literal length for null, false, true; zero for the number code
   function automatic logic [2:0] lit_len(input value_type k);
      logic [2:0] len;
      unique case (k)
         TY_NULL:  len = 3'd4;
         TY_FALSE: len = 3'd5;
         TY_TRUE:  len = 3'd4;
         default:  len = 3'd0;
      endcase
      return len;
   endfunction

   // expected character of a literal at a position
   function automatic logic [7:0] lit_char(input value_type k, input logic [2:0] p);
      logic [7:0] c;
      c = CH_NUL;
      unique case (k)
         TY_NULL: begin
            unique case (p)
               3'd0:    c = "n";
               3'd1:    c = "u";
               3'd2:    c = "l";
               3'd3:    c = "l";
               default: c = CH_NUL;
            endcase
         end
         TY_FALSE: begin
            unique case (p)
               3'd0:    c = "f";
               3'd1:    c = "a";
               3'd2:    c = "l";
               3'd3:    c = "s";
               3'd4:    c = "e";
               default: c = CH_NUL;
            endcase
         end
         TY_TRUE: begin
            unique case (p)
               3'd0:    c = "t";
               3'd1:    c = "r";
               3'd2:    c = "u";
               3'd3:    c = "e";
               default: c = CH_NUL;
            endcase
         end
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

### design/json_scalar_validator.sv
`default_nettype none
// Checks a text that arrives one byte per request, a zero byte ending it, and
// reports whether it holds exactly one JSON scalar (true, false, null or a
// number) with optional space, tab, LF or CR around it. One response comes
// out for each terminator: status in bits 1:0 (ok, expect value, invalid
// value, root not singular) and value type in bits 3:2 (null, false, true,
// number; null on any error). The first error wins and later bytes are
// ignored until the terminator, after which the parser is back at its reset
// state. The per-byte state machine updates in the cycle of acceptance and a
// terminator loads the response register, so a byte can be taken in every
// cycle. Non-terminator bytes are taken even while a response waits; only a
// terminator waits for the response register to drain. Numeric magnitude is
// not checked.
module json_scalar_validator (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // text_byte[7:0]
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // status[1:0], value_type[3:2], zero[7:4]
);

   jsv_pkg::phase_type  phase_ff, phase_in;
   jsv_pkg::value_type  kind_ff, kind_in;
   logic [2:0]          pos_ff, pos_in;
   jsv_pkg::status_type err_ff, err_in;

   logic                rsp_valid_ff, rsp_valid_in;
   jsv_pkg::status_type rsp_status_ff, rsp_status_in;
   jsv_pkg::value_type  rsp_type_ff, rsp_type_in;

   logic       accept;
   logic       is_term;
   logic [7:0] b;

   assign b       = req_tdata;
   assign is_term = (b == jsv_pkg::CH_NUL);

   // only a terminator needs room in the response register
   assign req_tready = !rsp_valid_ff || rsp_tready || !is_term;
   assign accept     = req_tvalid && req_tready;

   // result for a terminator seen in the current phase
   always_comb begin
      rsp_status_in = jsv_pkg::ST_OK;
      rsp_type_in   = jsv_pkg::TY_NULL;
      unique case (phase_ff)
         jsv_pkg::PH_LEAD: rsp_status_in = jsv_pkg::ST_EXPECT;
         jsv_pkg::PH_INT, jsv_pkg::PH_ZERO, jsv_pkg::PH_FRAC, jsv_pkg::PH_EXPDIG:
            rsp_type_in = jsv_pkg::TY_NUMBER;
         jsv_pkg::PH_TRAIL: rsp_type_in = kind_ff;
         jsv_pkg::PH_ERROR: begin
            rsp_status_in = (err_ff == jsv_pkg::ST_OK) ? jsv_pkg::ST_INVALID : err_ff;
         end
         default: rsp_status_in = jsv_pkg::ST_INVALID;
      endcase
      if (rsp_status_in != jsv_pkg::ST_OK) begin
         rsp_type_in = jsv_pkg::TY_NULL;
      end
   end

   // per-byte parser step
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      pos_in   = pos_ff;
      err_in   = err_ff;
      if (is_term) begin
         phase_in = jsv_pkg::PH_LEAD;
         kind_in  = jsv_pkg::TY_NULL;
         pos_in   = 3'd0;
         err_in   = jsv_pkg::ST_OK;
      end else begin
         unique case (phase_ff)
            jsv_pkg::PH_LEAD: begin
               priority if (jsv_pkg::is_ws(b)) begin
               end else if (b == jsv_pkg::CH_T) begin
                  kind_in = jsv_pkg::TY_TRUE;  pos_in = 3'd1; phase_in = jsv_pkg::PH_LIT;
               end else if (b == jsv_pkg::CH_F) begin
                  kind_in = jsv_pkg::TY_FALSE; pos_in = 3'd1; phase_in = jsv_pkg::PH_LIT;
               end else if (b == jsv_pkg::CH_N) begin
                  kind_in = jsv_pkg::TY_NULL;  pos_in = 3'd1; phase_in = jsv_pkg::PH_LIT;
               end else if (b == jsv_pkg::CH_MINUS) begin
                  phase_in = jsv_pkg::PH_SIGN;
               end else if (b == jsv_pkg::CH_ZERO) begin
                  phase_in = jsv_pkg::PH_ZERO;
               end else if (jsv_pkg::is_digit(b)) begin
                  phase_in = jsv_pkg::PH_INT;
               end else begin
                  err_in = jsv_pkg::ST_INVALID; phase_in = jsv_pkg::PH_ERROR;
               end
            end
            jsv_pkg::PH_LIT: begin
               if (kind_ff == jsv_pkg::TY_NUMBER || pos_ff >= jsv_pkg::lit_len(kind_ff)
                   || b != jsv_pkg::lit_char(kind_ff, pos_ff)) begin
                  err_in = jsv_pkg::ST_INVALID; phase_in = jsv_pkg::PH_ERROR;
               end else begin
                  pos_in = pos_ff + 3'd1;
                  if (pos_in == jsv_pkg::lit_len(kind_ff)) begin
                     phase_in = jsv_pkg::PH_TRAIL;
                  end
               end
            end
            jsv_pkg::PH_SIGN: begin
               priority if (b == jsv_pkg::CH_ZERO) begin
                  phase_in = jsv_pkg::PH_ZERO;
               end else if (jsv_pkg::is_digit(b)) begin
                  phase_in = jsv_pkg::PH_INT;
               end else begin
                  err_in = jsv_pkg::ST_INVALID; phase_in = jsv_pkg::PH_ERROR;
               end
            end
            jsv_pkg::PH_INT, jsv_pkg::PH_ZERO: begin
               // a digit after a leading zero ends the number
               priority if (phase_ff == jsv_pkg::PH_INT && jsv_pkg::is_digit(b)) begin
               end else if (b == jsv_pkg::CH_DOT) begin
                  phase_in = jsv_pkg::PH_DOT;
               end else if (b == jsv_pkg::CH_LOW_E || b == jsv_pkg::CH_UP_E) begin
                  phase_in = jsv_pkg::PH_EXP;
               end else begin
                  kind_in = jsv_pkg::TY_NUMBER;
                  if (jsv_pkg::is_ws(b)) begin
                     phase_in = jsv_pkg::PH_TRAIL;
                  end else begin
                     err_in = jsv_pkg::ST_NOTSING; phase_in = jsv_pkg::PH_ERROR;
                  end
               end
            end
            jsv_pkg::PH_DOT: begin
               if (jsv_pkg::is_digit(b)) begin
                  phase_in = jsv_pkg::PH_FRAC;
               end else begin
                  err_in = jsv_pkg::ST_INVALID; phase_in = jsv_pkg::PH_ERROR;
               end
            end
            jsv_pkg::PH_FRAC: begin
               priority if (jsv_pkg::is_digit(b)) begin
               end else if (b == jsv_pkg::CH_LOW_E || b == jsv_pkg::CH_UP_E) begin
                  phase_in = jsv_pkg::PH_EXP;
               end else begin
                  kind_in = jsv_pkg::TY_NUMBER;
                  if (jsv_pkg::is_ws(b)) begin
                     phase_in = jsv_pkg::PH_TRAIL;
                  end else begin
                     err_in = jsv_pkg::ST_NOTSING; phase_in = jsv_pkg::PH_ERROR;
                  end
               end
            end
            jsv_pkg::PH_EXP: begin
               priority if (b == jsv_pkg::CH_PLUS || b == jsv_pkg::CH_MINUS) begin
                  phase_in = jsv_pkg::PH_EXPSIGN;
               end else if (jsv_pkg::is_digit(b)) begin
                  phase_in = jsv_pkg::PH_EXPDIG;
               end else begin
                  err_in = jsv_pkg::ST_INVALID; phase_in = jsv_pkg::PH_ERROR;
               end
            end
            jsv_pkg::PH_EXPSIGN: begin
               if (jsv_pkg::is_digit(b)) begin
                  phase_in = jsv_pkg::PH_EXPDIG;
               end else begin
                  err_in = jsv_pkg::ST_INVALID; phase_in = jsv_pkg::PH_ERROR;
               end
            end
            jsv_pkg::PH_EXPDIG: begin
               if (!jsv_pkg::is_digit(b)) begin
                  kind_in = jsv_pkg::TY_NUMBER;
                  if (jsv_pkg::is_ws(b)) begin
                     phase_in = jsv_pkg::PH_TRAIL;
                  end else begin
                     err_in = jsv_pkg::ST_NOTSING; phase_in = jsv_pkg::PH_ERROR;
                  end
               end
            end
            jsv_pkg::PH_TRAIL: begin
               // extra text after a complete value
               if (!jsv_pkg::is_ws(b)) begin
                  err_in = jsv_pkg::ST_NOTSING; phase_in = jsv_pkg::PH_ERROR;
               end
            end
            jsv_pkg::PH_ERROR: begin
            end
            default: begin
               err_in = jsv_pkg::ST_INVALID; phase_in = jsv_pkg::PH_ERROR;
            end
         endcase
      end
   end

   // response register: load on terminator, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && is_term) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= jsv_pkg::PH_LEAD;
         kind_ff      <= jsv_pkg::TY_NULL;
         pos_ff       <= 3'd0;
         err_ff       <= jsv_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            kind_ff  <= kind_in;
            pos_ff   <= pos_in;
            err_ff   <= err_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && is_term) begin
         rsp_status_ff <= rsp_status_in;
         rsp_type_ff   <= rsp_type_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_type_ff, rsp_status_ff};

`ifndef ASSERT_OFF
   // a terminator always returns the parser to the leading phase with a response pending
   a_term_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && is_term) |=> (rsp_tvalid && phase_ff == jsv_pkg::PH_LEAD
                               && err_ff == jsv_pkg::ST_OK))
      else $error("terminator did not restart parser");

   // an error response never carries a value type
   a_err_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status_ff != jsv_pkg::ST_OK) |-> (rsp_type_ff == jsv_pkg::TY_NULL))
      else $error("error response with a value type");

   // the error phase always holds a latched error code
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == jsv_pkg::PH_ERROR) |-> (err_ff != jsv_pkg::ST_OK))
      else $error("error phase without error code");
`endif

endmodule
`default_nettype wire
